[sv/ppid_pkg.sv]
// Package for the positional PID controller with error dead band.
// Holds field widths, register reset values, register indexes, clamp codes and shared types.
// No dependencies.
package ppid_pkg;

    localparam int DATA_W     = 16;
    localparam int BAND_W     = 15;
    localparam int ERR_W      = DATA_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int INTEG_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W   = GAIN_W + 1 + INTEG_W;
    localparam int PROD_D_W   = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W      = PROD_I_W + 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FRAC_BITS_DEFAULT = 8;

    // Register reset values (gains about 7.419, 0.269, 7.516; band 1.5; max 100.0).
    localparam logic [GAIN_W-1:0] GAIN_PROP_RESET  = 16'd1899;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RESET = 16'd69;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RESET = 16'd1924;
    localparam logic [BAND_W-1:0] DEAD_BAND_RESET  = 15'd384;
    localparam logic [DATA_W-1:0] OUTPUT_MAX_RESET = 16'd25600;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_MAX = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_LOW  = 2'd1,
        CLAMP_HIGH = 2'd2
    } clamp_status_t;

    // Error terms produced by the front stage for one item.
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DIFF_W-1:0]  diff;
        logic signed [INTEG_W-1:0] integ;
    } front_t;

endpackage

[sv/ppid_front.sv]
// Front stage of the PID controller: error, dead band and saturating integral.
// Purely combinational; the caller registers the result and keeps the state.
// Depends on ppid_pkg.
module ppid_front
    import ppid_pkg::*;
(
    input  logic signed [DATA_W-1:0]  target_value,
    input  logic signed [DATA_W-1:0]  measured_value,
    input  logic        [BAND_W-1:0]  dead_band_width,
    input  logic signed [ERR_W-1:0]   prev_err,
    input  logic signed [INTEG_W-1:0] integ,
    output front_t                    result
);

    localparam logic signed [INTEG_W:0] INTEG_MAX = (INTEG_W+1)'((64'sd1 <<< (INTEG_W-1)) - 1);
    localparam logic signed [INTEG_W:0] INTEG_MIN = -(INTEG_W+1)'(64'sd1 <<< (INTEG_W-1));

    logic signed [ERR_W-1:0]   raw_err;
    logic signed [ERR_W:0]     band_pos;
    logic signed [ERR_W:0]     band_neg;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   acc;

    assign raw_err  = ERR_W'(measured_value) - ERR_W'(target_value);
    assign band_pos = $signed({{(ERR_W+1-BAND_W){1'b0}}, dead_band_width});
    assign band_neg = -band_pos;

    always_comb begin
        // An error exactly on the band edge is kept.
        if (((ERR_W+1)'(raw_err) < band_pos) && ((ERR_W+1)'(raw_err) > band_neg)) begin
            err = '0;
        end else begin
            err = raw_err;
        end
    end

    assign acc = (INTEG_W+1)'(integ) + (INTEG_W+1)'(err);

    always_comb begin
        result.err  = err;
        result.diff = DIFF_W'(err) - DIFF_W'(prev_err);
        priority if (acc > INTEG_MAX) begin
            result.integ = INTEG_MAX[INTEG_W-1:0];
        end else if (acc < INTEG_MIN) begin
            result.integ = INTEG_MIN[INTEG_W-1:0];
        end else begin
            result.integ = acc[INTEG_W-1:0];
        end
    end

endmodule

[sv/ppid_clamp.sv]
// Output clamp of the PID controller: scales the full-precision sum and limits it.
// Purely combinational; gives the drive value and the clamp status code.
// Depends on ppid_pkg.
module ppid_clamp
    import ppid_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic signed [SUM_W-1:0]  sum,
    input  logic        [DATA_W-1:0] output_max,
    output logic        [DATA_W-1:0] drive_value,
    output clamp_status_t            clamp_status
);

    logic [SUM_W-1:0] scaled;

    // Only used when the sum is non-negative, so a logical shift is exact.
    assign scaled = $unsigned(sum) >> FRAC_BITS;

    always_comb begin
        priority if (sum < 0) begin
            drive_value  = '0;
            clamp_status = CLAMP_LOW;
        end else if (scaled > SUM_W'(output_max)) begin
            drive_value  = output_max;
            clamp_status = CLAMP_HIGH;
        end else begin
            drive_value  = scaled[DATA_W-1:0];
            clamp_status = CLAMP_NONE;
        end
    end

endmodule

[sv/positional_pid_deadband.sv]
// Top level of the positional PID controller with error dead band.
// Five-register pipeline around ppid_front and ppid_clamp; uses ppid_pkg.
//
//   channel   direction  tdata fields (low bit up)                tuser
//   s_        in         target_value[15:0], measured_value[31:16]  -
//   m_        out        drive_value[15:0], clamp_status[17:16]     -
//   cfg_      in         cfg_addr selects a register, cfg_wdata     -
//
// One item per cycle unless stalled; m_tvalid follows the err, prod, sum and out registers.
// The integral and previous error update as the item leaves the input register,
// so the saturating 32-bit add is the loop that sets the rate.
// Each stage moves on when the next one is empty or moving, so bubbles close up
// under a stalled output. Reset clears all valid flags and the state, and loads
// the configuration registers with their reset values.
module positional_pid_deadband
    import ppid_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // target_value[15:0], measured_value[31:16]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // drive_value[15:0], clamp_status[17:16], zeros
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [GAIN_W-1:0] gain_prop_reg;
    logic [GAIN_W-1:0] gain_integ_reg;
    logic [GAIN_W-1:0] gain_deriv_reg;
    logic [BAND_W-1:0] dead_band_reg;
    logic [DATA_W-1:0] output_max_reg;

    // Stage valid flags.
    logic v_in_reg, v_err_reg, v_prod_reg, v_sum_reg, v_out_reg;
    logic rdy_in, rdy_err, rdy_prod, rdy_sum, rdy_out;

    // Payload and state registers.
    logic signed [DATA_W-1:0]   target_reg, measured_reg;
    logic signed [ERR_W-1:0]    err_reg;      // also the previous error
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [INTEG_W-1:0]  integ_reg;    // the running integral
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic        [DATA_W-1:0]   drive_reg;
    clamp_status_t              status_reg;

    front_t                     front_next;
    logic signed [SUM_W-1:0]    sum_next;
    logic        [DATA_W-1:0]   drive_next;
    clamp_status_t              status_next;

    assign rdy_out  = !v_out_reg  || m_tready;
    assign rdy_sum  = !v_sum_reg  || rdy_out;
    assign rdy_prod = !v_prod_reg || rdy_sum;
    assign rdy_err  = !v_err_reg  || rdy_prod;
    assign rdy_in   = !v_in_reg   || rdy_err;
    assign s_tready = rdy_in;

    ppid_front u_front (
        .target_value    (target_reg),
        .measured_value  (measured_reg),
        .dead_band_width (dead_band_reg),
        .prev_err        (err_reg),
        .integ           (integ_reg),
        .result          (front_next)
    );

    assign sum_next = SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg) + SUM_W'(prod_d_reg);

    ppid_clamp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_clamp (
        .sum          (sum_reg),
        .output_max   (output_max_reg),
        .drive_value  (drive_next),
        .clamp_status (status_next)
    );

    // Control, state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg       <= 1'b0;
            v_err_reg      <= 1'b0;
            v_prod_reg     <= 1'b0;
            v_sum_reg      <= 1'b0;
            v_out_reg      <= 1'b0;
            err_reg        <= '0;
            integ_reg      <= '0;
            gain_prop_reg  <= GAIN_PROP_RESET;
            gain_integ_reg <= GAIN_INTEG_RESET;
            gain_deriv_reg <= GAIN_DERIV_RESET;
            dead_band_reg  <= DEAD_BAND_RESET;
            output_max_reg <= OUTPUT_MAX_RESET;
        end else begin
            if (rdy_in)   v_in_reg   <= s_tvalid;
            if (rdy_err)  v_err_reg  <= v_in_reg;
            if (rdy_prod) v_prod_reg <= v_err_reg;
            if (rdy_sum)  v_sum_reg  <= v_prod_reg;
            if (rdy_out)  v_out_reg  <= v_sum_reg;

            // The state advances exactly once per item.
            if (rdy_err && v_in_reg) begin
                err_reg   <= front_next.err;
                integ_reg <= front_next.integ;
            end

            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_GAIN_PROP:  gain_prop_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_INTEG: gain_integ_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_DERIV: gain_deriv_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_DEAD_BAND:  dead_band_reg  <= cfg_wdata[BAND_W-1:0];
                    REG_OUTPUT_MAX: output_max_reg <= cfg_wdata[DATA_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (rdy_in && s_tvalid) begin
            target_reg   <= $signed(s_tdata[DATA_W-1:0]);
            measured_reg <= $signed(s_tdata[2*DATA_W-1:DATA_W]);
        end
        if (rdy_err && v_in_reg) begin
            diff_reg <= front_next.diff;
        end
        if (rdy_prod && v_err_reg) begin
            prod_p_reg <= PROD_P_W'($signed({1'b0, gain_prop_reg})) * PROD_P_W'(err_reg);
            prod_i_reg <= PROD_I_W'($signed({1'b0, gain_integ_reg})) * PROD_I_W'(integ_reg);
            prod_d_reg <= PROD_D_W'($signed({1'b0, gain_deriv_reg})) * PROD_D_W'(diff_reg);
        end
        if (rdy_sum && v_prod_reg) begin
            sum_reg <= sum_next;
        end
        if (rdy_out && v_sum_reg) begin
            drive_reg  <= drive_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = v_out_reg;
    assign m_tdata  = {6'd0, status_reg, drive_reg};

endmodule

[tb/testbench.sv]
// Self-checking testbench for positional_pid_deadband: streams samples, tracks the
// controller state in a scoreboard class and compares every drive and clamp status.
// Depends on ppid_pkg and the positional_pid_deadband RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ppid_pkg::*;

    localparam int     FRAC          = FRAC_BITS_DEFAULT;
    localparam int     STALL_LIMIT   = 3000;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     REPORT_CAP    = 40;
    localparam longint INTEG_MAX     = 64'sd2147483647;
    localparam longint INTEG_MIN     = -64'sd2147483648;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = REG_OUTPUT_MAX + 3'd1;

    typedef struct {
        logic [DATA_W-1:0] drive;
        clamp_status_t     status;
    } drive_t;

    class pid_tracker;
        logic [GAIN_W-1:0]        kp, ki, kd;
        logic [BAND_W-1:0]        band;
        logic [DATA_W-1:0]        max_out;
        logic signed [INTEG_W-1:0] integ;
        logic signed [ERR_W-1:0]   prev_err;
        drive_t pending_drives[$];
        int samples, checked, mismatches;
        int in_range, at_zero, at_max, sat_high, sat_low;

        function new();
            kp = GAIN_PROP_RESET;
            ki = GAIN_INTEG_RESET;
            kd = GAIN_DERIV_RESET;
            band = DEAD_BAND_RESET;
            max_out = OUTPUT_MAX_RESET;
            integ = '0;
            prev_err = '0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_GAIN_PROP:  kp = data;
                REG_GAIN_INTEG: ki = data;
                REG_GAIN_DERIV: kd = data;
                REG_DEAD_BAND:  band = data[BAND_W-1:0];
                REG_OUTPUT_MAX: max_out = data;
                default: ;
            endcase
        endfunction

        // Advances the controller by one accepted sample and queues its drive.
        function void take_sample(logic [DATA_W-1:0] tgt_bits, logic [DATA_W-1:0] meas_bits);
            longint err, acc, sum, quot;
            drive_t want;
            err = longint'($signed(meas_bits)) - longint'($signed(tgt_bits));
            if (err < longint'(band) && err > -longint'(band)) err = 0;
            acc = longint'(integ) + err;
            if (acc > INTEG_MAX) begin
                acc = INTEG_MAX;
                sat_high++;
            end else if (acc < INTEG_MIN) begin
                acc = INTEG_MIN;
                sat_low++;
            end
            integ = acc[INTEG_W-1:0];
            sum = longint'(kp) * err + longint'(ki) * longint'(integ)
                + longint'(kd) * (err - longint'(prev_err));
            if (sum < 0) begin
                want.drive = '0;
                want.status = CLAMP_LOW;
            end else begin
                quot = sum >>> FRAC;
                if (quot > longint'(max_out)) begin
                    want.drive = max_out;
                    want.status = CLAMP_HIGH;
                end else begin
                    want.drive = quot[DATA_W-1:0];
                    want.status = CLAMP_NONE;
                end
            end
            prev_err = err[ERR_W-1:0];
            pending_drives.push_back(want);
            samples++;
        endfunction

        function void compare_drive(logic [DATA_W-1:0] drive, logic [STATUS_W-1:0] status_bits);
            drive_t want;
            if (pending_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected item, drive %0d status %0d", $time, drive,
                             status_bits);
                return;
            end
            want = pending_drives.pop_front();
            checked++;
            case (want.status)
                CLAMP_LOW:  at_zero++;
                CLAMP_HIGH: at_max++;
                default:    in_range++;
            endcase
            if (drive !== want.drive) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: drive_value expected %0d, actual %0d", $time, want.drive,
                             drive);
            end
            if (status_bits !== want.status) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: clamp_status expected %0d, actual %0d", $time,
                             want.status, status_bits);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;   // target_value[15:0], measured_value[31:16]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;        // drive_value[15:0], clamp_status[17:16], zeros
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    pid_tracker sb = new();
    int     burst_left = 0;
    int     settings_used = 1;
    longint drift = 0;

    positional_pid_deadband dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.take_sample(s_tdata[15:0], s_tdata[31:16]);
        if (aresetn && m_tvalid && m_tready)
            sb.compare_drive(m_tdata[15:0], m_tdata[17:16]);
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("positional_pid_deadband verification failed");
        $finish;
    end

    // Receiver: switches among stall patterns, and twice holds off for a long
    // stretch so that the pipeline fills and the input stalls.
    initial begin : result_sink
        int mode, left, holds_done;
        mode = 0;
        left = 0;
        holds_done = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (holds_done < 2 && sb.checked >= 60 + 400 * holds_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (left % 3 != 0);
            endcase
        end
    end

    function automatic logic [31:0] pair_for_error(longint err);
        longint tgt_lo, tgt_hi, tgt;
        tgt_lo = (err < 0) ? -32768 - err : -32768;
        tgt_hi = (err < 0) ? 32767 : 32767 - err;
        tgt = tgt_lo + longint'($urandom_range(0, 32'(tgt_hi - tgt_lo)));
        return {16'(tgt + err), 16'(tgt)};
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 2047));
            default: return 16'($urandom());
        endcase
    endfunction

    // Offers one item, waits for its handshake, then may open a gap between bursts.
    task automatic offer(input logic [31:0] item_word);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= item_word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        drift += longint'($signed(item_word[31:16])) - longint'($signed(item_word[15:0]));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_drives.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.set_reg(addr, data);
    endtask

    task automatic program_regs(input logic [15:0] kp, ki, kd, band_word, max_word);
        wait_idle();
        write_reg(REG_GAIN_PROP, kp);
        write_reg(REG_GAIN_INTEG, ki);
        write_reg(REG_GAIN_DERIV, kd);
        write_reg(REG_DEAD_BAND, band_word);
        write_reg(REG_OUTPUT_MAX, max_word);
        // Indexes past the last register must leave every setting alone.
        write_reg(REG_SPARE_FIRST + CFG_ADDR_W'($urandom_range(0, 2)), 16'($urandom()));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly small errors steered back toward zero so the integral stays in a
    // useful range, plus dead band edges and fully random samples.
    task automatic run_random(input int count);
        longint err, band_now;
        int kind;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            band_now = longint'(sb.band);
            if (kind < 15) begin
                offer($urandom());
            end else if (kind < 30) begin
                err = band_now + longint'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1)) err = -err;
                offer(pair_for_error(err));
            end else begin
                err = longint'($urandom_range(0, 32'(band_now + 2048)));
                if ((drift > 0) == ($urandom_range(0, 3) != 0)) err = -err;
                offer(pair_for_error(err));
            end
        end
    endtask

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: dead band edges and the extremes of both fields.
        offer({16'h0000, 16'h0000});
        offer(pair_for_error(384));
        offer(pair_for_error(-384));
        offer(pair_for_error(383));
        offer(pair_for_error(-383));
        offer({16'h7FFF, 16'h8000});
        offer({16'h8000, 16'h7FFF});
        offer({16'h7FFF, 16'h7FFF});
        offer({16'h8000, 16'h8000});
        offer(pair_for_error(385));
        run_random(150);

        // Unit proportional gain only: rounding of fractions and the clamp edges.
        program_regs(16'd1, 16'd0, 16'd0, 16'd0, 16'd2);
        offer(pair_for_error(-1));
        offer(pair_for_error(1));
        offer(pair_for_error(255));
        offer(pair_for_error(256));
        offer(pair_for_error(512));
        offer(pair_for_error(768));
        wait_idle();
        write_reg(REG_OUTPUT_MAX, 16'd0);
        cfg_we <= 1'b0;
        offer(pair_for_error(0));
        offer(pair_for_error(256));

        repeat (6) begin
            program_regs(pick_gain(), pick_gain(), pick_gain(),
                         16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1023)),
                         16'($urandom()));
            run_random(70);
        end

        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(60);
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(60);

        // The largest errors of both signs with the widest products.
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        repeat (10) offer({16'h7FFF, 16'h8000});
        repeat (10) offer({16'h8000, 16'h7FFF});
        run_random(20);

        wait_idle();
        $display("Covered %0d samples under %0d register settings: %0d in range, %0d at zero, %0d at maximum.",
                 sb.samples, settings_used, sb.in_range, sb.at_zero, sb.at_max);
        $display("Integral hit its upper limit %0d times and its lower limit %0d times; %0d mismatches.",
                 sb.sat_high, sb.sat_low, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_drives.size() == 0)
            $display("positional_pid_deadband verification clean");
        else
            $display("positional_pid_deadband verification failed");
        $finish;
    end

endmodule
